// ===== rtl/assert_macros.svh =====
// assertion helpers for the filter block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, a, b)
`define ASSERT_NEXT(label, clk, rstn, a, b)
`endif
`endif

// ===== rtl/cbiq_pkg.sv =====
// ----------------------------------------------------------------------------
// cbiq_pkg
// shared types and constants of the cascaded biquad filter
// ----------------------------------------------------------------------------
package cbiq_pkg;
    localparam int SECTIONS_DEF = 8;
    localparam int NCOEF = 6;
    localparam int CW = 24;
    localparam int DW = 32;
    localparam int PW = 56;
    localparam int ACCW = 64;

    localparam logic [2:0] SEL_G  = 3'd0;
    localparam logic [2:0] SEL_A1 = 3'd1;
    localparam logic [2:0] SEL_A2 = 3'd2;
    localparam logic [2:0] SEL_B0 = 3'd3;
    localparam logic [2:0] SEL_B1 = 3'd4;
    localparam logic [2:0] SEL_B2 = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CLEAR, ST_LOAD, ST_MUL, ST_ROUND, ST_WB, ST_OUT
    } state_t;

    function automatic logic signed [CW-1:0] coef_reset(input logic first,
                                                       input logic [2:0] sel);
        logic signed [CW-1:0] v;
        v = '0;
        case (sel)
            SEL_G:   v = first ? 24'sd38533 : 24'sd1048576;
            SEL_A1:  v = first ? -24'sd1794738 : '0;
            SEL_A2:  v = first ? 24'sd785539 : '0;
            SEL_B0:  v = 24'sd1048576;
            SEL_B1:  v = first ? -24'sd1025595 : '0;
            SEL_B2:  v = first ? 24'sd1048576 : '0;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

// ===== rtl/cascaded_biquad_iir_filter.sv =====
// each multiply is one load state and 32 shift-add steps, six per section
// throughput: one request at a time, next sample accepted once the result is taken
// coefficient write requests are accepted back to back while no result or section-count write
// is pending; a clear pass over all SECTIONS*6 coefficient entries follows reset
// reset: synchronous active-low aresetn, delays zeroed and coefficients reloaded by the pass
// ----------------------------------------------------------------------------
// cascaded_biquad_iir_filter
// direct form II biquad cascade on one bit-serial multiply-accumulate unit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cascaded_biquad_iir_filter #(
    parameter int SECTIONS = cbiq_pkg::SECTIONS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [0:0]  s_tuser,   // mode
    input  logic [47:0] s_tdata,   // sample_in, section_index, coef_select, coef_value, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sample_out
    output logic [0:0]  m_tuser,   // saturated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data   // active_sections
);
    import cbiq_pkg::*;

    localparam int SW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int DEPTH = SECTIONS * NCOEF;
    localparam int AW = $clog2(DEPTH);
    localparam int MW = 6;

    state_t state_reg, state_next;
    logic [3:0] nsec_reg;
    logic [AW-1:0] clr_reg;
    logic [2:0] clr_sel_reg;
    logic signed [CW-1:0] cmem [DEPTH];
    logic signed [DW-1:0] d1mem [SECTIONS];
    logic signed [DW-1:0] d2mem [SECTIONS];
    logic signed [CW-1:0] crd_reg;
    logic signed [DW-1:0] d1_reg, d2_reg, x_reg, w_reg;
    logic [SW-1:0] sec_reg;
    logic [2:0] term_reg;
    logic [MW-1:0] bit_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [ACCW-1:0] mcand_reg;
    logic [DW-1:0] mplier_reg;
    logic sat_reg;
    logic phase_reg; // 0 = w sum, 1 = y sum
    logic [15:0] out_reg;
    logic ovalid_reg;

    logic [3:0] nclamp;
    assign nclamp = ({1'b0, nsec_reg} > 5'(SECTIONS)) ? 4'(SECTIONS) : nsec_reg;

    logic [2:0] wsec;
    logic [2:0] wsel;
    assign wsec = s_tdata[18:16];
    assign wsel = s_tdata[21:19];
    logic acc_in;
    assign acc_in = s_tvalid && s_tready;

    // coefficient address of current term
    logic [2:0] csel;
    always_comb begin
        csel = phase_reg ? 3'(term_reg + 3'd3) : term_reg;
    end
    logic [AW-1:0] caddr;
    assign caddr = AW'(sec_reg * NCOEF) + AW'(csel);

    // multiplier operand of current term
    logic signed [DW-1:0] opnd;
    always_comb begin
        case (term_reg)
            3'd0:    opnd = phase_reg ? w_reg : x_reg;
            3'd1:    opnd = d1_reg;
            default: opnd = d2_reg;
        endcase
    end

    // first step takes the coefficient straight from the registered read
    logic signed [ACCW-1:0] mc;
    assign mc = (bit_reg == '0) ? ACCW'(crd_reg) : mcand_reg;

    // rounding and saturation of the accumulated sum
    logic last_sec;
    assign last_sec = ({1'b0, sec_reg} + 1'b1) >= (SW+1)'(nclamp);
    logic signed [ACCW-1:0] r20, r25;
    logic sat20, sat25;
    logic signed [DW-1:0] v20;
    logic signed [15:0] v25;
    always_comb begin
        r20 = (acc_reg + ACCW'(64'sd1 <<< 19)) >>> 20;
        r25 = (acc_reg + ACCW'(64'sd1 <<< 24)) >>> 25;
        sat20 = (r20 > ACCW'(64'sd2147483647)) || (r20 < -ACCW'(64'sd2147483648));
        sat25 = (r25 > ACCW'(64'sd32767)) || (r25 < -ACCW'(64'sd32768));
        v20 = sat20 ? (r20[ACCW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}})
                    : r20[DW-1:0];
        v25 = sat25 ? (r25[ACCW-1] ? 16'sh8000 : 16'sh7fff) : r25[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_CLEAR;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == AW'(DEPTH-1)) state_next = ST_IDLE;
            ST_IDLE: begin
                // a pending register write goes first
                s_tready = !ovalid_reg && !cfg_valid;
                if (acc_in && !s_tuser[0]) begin
                    state_next = (nclamp == 4'd0) ? ST_OUT : ST_LOAD;
                end
            end
            ST_LOAD:  state_next = ST_MUL;
            ST_MUL:   if (bit_reg == MW'(DW-1)) state_next =
                          (term_reg == 3'd2) ? ST_ROUND : ST_LOAD;
            ST_ROUND: state_next = phase_reg ? (last_sec ? ST_OUT : ST_WB) : ST_LOAD;
            ST_WB:    state_next = ST_LOAD;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign cfg_ready = (state_reg == ST_IDLE) || (state_reg == ST_CLEAR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nsec_reg <= 4'd1;
            clr_reg <= '0;
            clr_sel_reg <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) nsec_reg <= cfg_data;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
                clr_sel_reg <= (clr_sel_reg == 3'(NCOEF-1)) ? 3'd0 : clr_sel_reg + 1'b1;
            end
            if (state_reg == ST_OUT) ovalid_reg <= 1'b1;
            else if (m_tready) ovalid_reg <= 1'b0;
        end
    end

    // coefficient and delay stores
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            cmem[clr_reg] <= coef_reset(clr_reg < AW'(NCOEF), clr_sel_reg);
            if (clr_reg < AW'(SECTIONS)) begin
                d1mem[SW'(clr_reg)] <= '0;
                d2mem[SW'(clr_reg)] <= '0;
            end
        end else if (acc_in && s_tuser[0] && (32'(wsec) < SECTIONS) && (wsel < 3'd6)) begin
            cmem[AW'(32'(wsec) * NCOEF + 32'(wsel))] <= s_tdata[45:22];
        end else if (state_reg == ST_ROUND && phase_reg) begin
            d1mem[sec_reg] <= w_reg;
            d2mem[sec_reg] <= d1_reg;
        end
        crd_reg <= cmem[caddr];
    end

    // datapath sequencing
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                x_reg <= DW'($signed(s_tdata[15:0])) <<< 5;
                sec_reg <= '0;
                term_reg <= '0;
                phase_reg <= 1'b0;
                sat_reg <= 1'b0;
                acc_reg <= '0;
                d1_reg <= d1mem[0];
                d2_reg <= d2mem[0];
                out_reg <= '0;
            end
            ST_LOAD: begin
                bit_reg <= '0;
                mplier_reg <= opnd;
            end
            ST_MUL: begin
                // shift-add: top bit of multiplier carries negative weight
                if (mplier_reg[0]) begin
                    if (bit_reg == MW'(DW-1)) begin
                        if ((!phase_reg) && term_reg != 3'd0) acc_reg <= acc_reg + mc;
                        else acc_reg <= acc_reg - mc;
                    end else begin
                        if ((!phase_reg) && term_reg != 3'd0) acc_reg <= acc_reg - mc;
                        else acc_reg <= acc_reg + mc;
                    end
                end
                mcand_reg <= mc <<< 1;
                mplier_reg <= mplier_reg >> 1;
                bit_reg <= bit_reg + 1'b1;
                if (bit_reg == MW'(DW-1)) term_reg <= (term_reg == 3'd2) ? 3'd0 : term_reg + 1'b1;
            end
            ST_ROUND: begin
                acc_reg <= '0;
                if (!phase_reg) begin
                    w_reg <= v20;
                    sat_reg <= sat_reg | sat20;
                    phase_reg <= 1'b1;
                end else if (last_sec) begin
                    out_reg <= v25;
                    sat_reg <= sat_reg | sat25;
                end else begin
                    x_reg <= v20;
                    sat_reg <= sat_reg | sat20;
                end
            end
            ST_WB: begin
                phase_reg <= 1'b0;
                sec_reg <= sec_reg + 1'b1;
                d1_reg <= d1mem[SW'(sec_reg + 1'b1)];
                d2_reg <= d2mem[SW'(sec_reg + 1'b1)];
            end
            default: ;
        endcase
    end

    logic [15:0] mdata_reg;
    logic msat_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT) begin
            mdata_reg <= out_reg;
            msat_reg <= sat_reg;
        end
    end
    assign m_tvalid = ovalid_reg;
    assign m_tdata = mdata_reg;
    assign m_tuser = msat_reg;

    `ASSERT_IMPLIES(a_no_in_busy, aclk, aresetn, state_reg != ST_IDLE, !s_tready)
    `ASSERT_NEXT(a_out_valid, aclk, aresetn, state_reg == ST_OUT, m_tvalid)
    `ASSERT_IMPLIES(a_term_range, aclk, aresetn, state_reg == ST_MUL, term_reg < 3'd3)
endmodule

// ===== bench/cascaded_biquad_iir_filter_tb.sv =====
// ----------------------------------------------------------------------------
// cascaded_biquad_iir_filter_tb
// checks the biquad cascade against an in-bench fixed point predictor,
// with coefficient writes, section count changes, random idling and stalls
// ----------------------------------------------------------------------------
module cascaded_biquad_iir_filter_tb;
    import cbiq_pkg::*;

    localparam int NSEC = 8;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam logic MODE_FILTER = 1'b0;
    localparam logic MODE_COEF = 1'b1;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [0:0]  s_tuser = '0;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = '0;

    always #5 aclk = ~aclk;

    cascaded_biquad_iir_filter #(.SECTIONS(NSEC)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic [15:0] sample;
        logic        sat;
    } filt_out_t;

    typedef struct packed {
        logic        mode;
        logic [47:0] data;
    } tx_item_t;

    // predictor state
    logic [3:0]         sections_reg;
    logic signed [31:0] dly1 [NSEC];
    logic signed [31:0] dly2 [NSEC];
    logic signed [23:0] coefs [NSEC][6];

    filt_out_t expected_samples[$];
    tx_item_t  tx_queue[$];
    int  tx_issued = 0;
    int  tx_accepted = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  rx_hold = 0;
    bit  timed_out = 0;

    function automatic logic signed [63:0] round_clip(input logic signed [63:0] acc,
                                                       input int sh,
                                                       input logic signed [63:0] lo,
                                                       input logic signed [63:0] hi,
                                                       inout logic flag);
        logic signed [63:0] r;
        r = (acc + (64'sd1 <<< (sh - 1))) >>> sh;
        if (r > hi) begin
            flag = 1'b1;
            return hi;
        end
        if (r < lo) begin
            flag = 1'b1;
            return lo;
        end
        return r;
    endfunction

    task automatic reset_predictor();
        sections_reg = 4'd1;
        for (int s = 0; s < NSEC; s++) begin
            dly1[s] = '0;
            dly2[s] = '0;
            coefs[s][SEL_G] = 24'sd1048576;
            coefs[s][SEL_A1] = '0;
            coefs[s][SEL_A2] = '0;
            coefs[s][SEL_B0] = 24'sd1048576;
            coefs[s][SEL_B1] = '0;
            coefs[s][SEL_B2] = '0;
        end
        coefs[0][SEL_G] = 24'sd38533;
        coefs[0][SEL_A1] = -24'sd1794738;
        coefs[0][SEL_A2] = 24'sd785539;
        coefs[0][SEL_B1] = -24'sd1025595;
        coefs[0][SEL_B2] = 24'sd1048576;
    endtask

    task automatic predict_item(input logic mode, input logic [47:0] d);
        int n;
        logic signed [63:0] x, y, w, acc, d1, d2;
        logic flag;
        filt_out_t r;
        flag = 1'b0;
        y = 0;
        if (mode == MODE_COEF) begin
            if (d[21:19] < 3'd6 && int'(d[18:16]) < NSEC)
                coefs[d[18:16]][d[21:19]] = d[45:22];
            return;
        end
        n = (sections_reg > NSEC) ? NSEC : sections_reg;
        x = 64'(signed'(d[15:0])) * 32;
        for (int s = 0; s < n; s++) begin
            d1 = dly1[s];
            d2 = dly2[s];
            acc = 64'(coefs[s][SEL_G]) * x - 64'(coefs[s][SEL_A1]) * d1
                - 64'(coefs[s][SEL_A2]) * d2;
            w = round_clip(acc, 20, -64'sd2147483648, 64'sd2147483647, flag);
            acc = 64'(coefs[s][SEL_B0]) * w + 64'(coefs[s][SEL_B1]) * d1
                + 64'(coefs[s][SEL_B2]) * d2;
            dly2[s] = d1[31:0];
            dly1[s] = w[31:0];
            if (s + 1 < n)
                x = round_clip(acc, 20, -64'sd2147483648, 64'sd2147483647, flag);
            else
                y = round_clip(acc, 25, -64'sd32768, 64'sd32767, flag);
        end
        r.sample = y[15:0];
        r.sat = flag;
        expected_samples.push_back(r);
    endtask

    // input stream driver, one request per accept
    always @(posedge aclk) begin
        tx_item_t t;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                tx_accepted++;
            if (tx_queue.size() != 0) begin
                t = tx_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= t.mode;
                s_tdata <= t.data;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // one request on the input stream, at times with a random gap first
    task automatic send_item(input logic mode, input logic [47:0] d);
        int ticket;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        predict_item(mode, d);
        tx_queue.push_back({mode, d});
        tx_issued++;
        ticket = tx_issued;
        while (tx_accepted < ticket) @(posedge aclk);
    endtask

    function automatic logic [47:0] pack_coef(input int sec, input int sel,
                                              input logic [23:0] v);
        return {2'b00, v, 3'(sel), 3'(sec), 16'h0000};
    endfunction

    task automatic send_sample(input logic [15:0] v);
        send_item(MODE_FILTER, {32'h0, v});
    endtask

    task automatic drain();
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_sections(input logic [3:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sections_reg = v;
    endtask

    task automatic test_reset_lowpass();
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'h7fff);
        send_sample(16'h7fff);
    endtask

    task automatic test_coef_writes();
        send_item(MODE_COEF, pack_coef(1, SEL_G, 24'h7fffff));
        send_item(MODE_COEF, pack_coef(1, SEL_B0, 24'h800000));
        send_item(MODE_COEF, pack_coef(7, SEL_B2, 24'h100000));
        send_item(MODE_COEF, pack_coef(2, 6, 24'h123456));
        send_item(MODE_COEF, pack_coef(3, 7, 24'hfedcba));
        write_sections(4'd2);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h1234);
    endtask

    task automatic test_section_counts();
        write_sections(4'd0);
        send_sample(16'h4000);
        write_sections(4'd15);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        write_sections(4'd8);
        send_sample(16'h0001);
    endtask

    task automatic test_random(input int count);
        int burst;
        int k;
        k = 0;
        while (k < count) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && k < count; i++, k++) begin
                if ($urandom_range(0, 4) == 0)
                    send_item(MODE_COEF, 48'({$urandom, $urandom}) & 48'h3fff_ffff_0000);
                else
                    send_sample(16'($urandom));
            end
            if ($urandom_range(0, 5) == 0)
                write_sections(4'($urandom_range(0, 15)));
            repeat ($urandom_range(0, 10)) @(posedge aclk);
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                rx_hold = 1;
                repeat (2000) @(posedge aclk);
                rx_hold = 0;
            end
            begin
                for (int i = 0; i < 6; i++)
                    send_sample(16'($urandom));
            end
        join
    endtask

    // receiver stalls on its own pattern, quiet stretches included
    always @(posedge aclk) begin
        if (rx_hold)
            m_tready <= 1'b0;
        else if (($urandom_range(0, 255) < 40))
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge aclk) begin
        filt_out_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h sat %b", m_tdata, m_tuser);
            end else begin
                e = expected_samples.pop_front();
                if (m_tdata !== e.sample || m_tuser[0] !== e.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h sat %b, got %h sat %b",
                                 e.sample, e.sat, m_tdata, m_tuser);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn || rx_hold)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        reset_predictor();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_lowpass();
        test_coef_writes();
        test_section_counts();
        test_backpressure();
        test_random(550);
        drain();
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
